// File: design/npa_pkg.sv
`timescale 1ns / 1ps

package npa_pkg;

  localparam int PORT_W     = 16;
  localparam int OWNER_W    = 16;
  localparam int COUNT_W    = 7;
  localparam int STATUS_W   = 3;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [PORT_W-1:0] PORT_MAX = 16'hFFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_REQ_ONE   = 2'd0,
    CMD_REQ_MULTI = 2'd1,
    CMD_RELEASE   = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOFREE   = 3'd1,
    ST_CONFLICT = 3'd2,
    ST_BADCOUNT = 3'd3,
    ST_NONE     = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_PORT = 2'd0,
    CFG_POOL_SIZE = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [OWNER_W-1:0] owner;
    logic [COUNT_W-1:0] count;
  } npa_in_t;

  typedef struct packed {
    logic [PORT_W-1:0]   port;
    logic [STATUS_W-1:0] status;
    logic                last;
  } npa_out_t;

  typedef struct packed {
    logic                load;
    logic                count_en;
    logic                rewind_zero;
    logic                rewind_start;
    logic                list_en;
    logic                release_en;
    logic                alloc_en;
    logic                emit;
    logic [STATUS_W-1:0] status;
  } npa_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             scan_done;
    logic             alloc_done;
    logic             held_zero;
    logic             held_eq_count;
    logic             count_zero;
    logic             free_zero;
    logic             free_short;
  } npa_sts_t;

endpackage

// File: design/npa_ram.sv
`timescale 1ns / 1ps

module npa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/npa_dp.sv
`timescale 1ns / 1ps

module npa_dp
  import npa_pkg::*;
#(
  parameter int POOL_DEPTH = 64,
  parameter int OWNER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  npa_in_t               item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  npa_ctl_t              ctl,
  output npa_sts_t              sts,
  output logic                  result_valid,
  output npa_out_t              result
);

  localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);

  logic [PORT_W-1:0]     base;
  logic [COUNT_W-1:0]    psize;
  logic [POOL_DEPTH-1:0] used;
  logic [IDX_W-1:0]      cursor;

  logic [CMD_W-1:0]      cmd_r;
  logic [OWNER_BITS-1:0] own_r;
  logic [COUNT_W-1:0]    count_r;

  logic [IDX_W-1:0]      pos;
  logic [CNT_W-1:0]      step;
  logic                  s_valid;
  logic [IDX_W-1:0]      s_pos;
  logic [CNT_W-1:0]      nheld;
  logic [CNT_W-1:0]      nfree;
  logic [CNT_W-1:0]      got;

  logic [OWNER_BITS-1:0] rdata;
  logic [16:0]           room;
  logic [16:0]           n_wide;
  logic [CNT_W-1:0]      n;
  logic [IDX_W-1:0]      start_pos;
  logic [IDX_W-1:0]      pos_inc;
  logic [COUNT_W-1:0]    want;
  logic                  issue;
  logic                  alloc_go;
  logic                  take;
  logic                  match;
  logic                  cfg_hit;

  npa_ram #(
    .WIDTH(OWNER_BITS),
    .DEPTH(POOL_DEPTH)
  ) u_owner_ram (
    .clk  (clk),
    .we   (take),
    .waddr(pos),
    .wdata(own_r),
    .raddr(pos),
    .rdata(rdata)
  );

  always_comb begin
    room   = 17'(PORT_MAX) - 17'(base) + 17'd1;
    n_wide = 17'(psize);
    if (n_wide > 17'(POOL_DEPTH)) begin
      n_wide = 17'(POOL_DEPTH);
    end
    if (n_wide > room) begin
      n_wide = room;
    end
    n = CNT_W'(n_wide);
  end

  assign start_pos = (8'(cursor) < 8'(n)) ? cursor : '0;
  assign pos_inc   = (8'(pos) + 8'd1 == 8'(n)) ? '0 : IDX_W'(8'(pos) + 8'd1);
  assign want      = (cmd_r == CMD_REQ_ONE) ? COUNT_W'(1) : count_r;
  assign issue     = (ctl.count_en | ctl.list_en | ctl.release_en) && (8'(step) < 8'(n));
  assign alloc_go  = ctl.alloc_en && (8'(step) < 8'(n)) && (8'(got) < 8'(want));
  assign take      = alloc_go && !used[pos];
  assign match     = s_valid && used[s_pos] && (rdata == own_r);
  assign cfg_hit   = cfg_we && (cfg_index == CFG_BASE_PORT || cfg_index == CFG_POOL_SIZE);

  assign sts.cmd           = cmd_r;
  assign sts.scan_done     = (step == n) && !s_valid;
  assign sts.alloc_done    = (8'(got) == 8'(want));
  assign sts.held_zero     = (nheld == '0);
  assign sts.held_eq_count = (8'(nheld) == 8'(count_r));
  assign sts.count_zero    = (count_r == '0);
  assign sts.free_zero     = (nfree == '0);
  assign sts.free_short    = (8'(nfree) < 8'(count_r));

  always_ff @(posedge clk) begin
    if (rst) begin
      base   <= '0;
      psize  <= '0;
      used   <= '0;
      cursor <= '0;
    end else begin
      if (cfg_hit) begin
        if (cfg_index == CFG_BASE_PORT) begin
          base <= cfg_data[PORT_W-1:0];
        end else begin
          psize <= cfg_data[COUNT_W-1:0];
        end
        used   <= '0;
        cursor <= '0;
      end
      if (take) begin
        used[pos] <= 1'b1;
        cursor    <= pos_inc;
      end
      if (ctl.release_en && match) begin
        used[s_pos] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid      <= 1'b0;
      result_valid <= 1'b0;
      step         <= '0;
      pos          <= '0;
      got          <= '0;
      nheld        <= '0;
      nfree        <= '0;
    end else begin
      result_valid <= 1'b0;
      s_valid      <= issue;
      s_pos        <= pos;
      if (ctl.load) begin
        cmd_r   <= item.cmd;
        own_r   <= OWNER_BITS'(item.owner);
        count_r <= item.count;
        pos     <= '0;
        step    <= '0;
        got     <= '0;
        nheld   <= '0;
        nfree   <= '0;
      end else if (ctl.rewind_zero) begin
        pos  <= '0;
        step <= '0;
        got  <= '0;
      end else if (ctl.rewind_start) begin
        pos  <= start_pos;
        step <= '0;
        got  <= '0;
      end else if (issue) begin
        pos  <= pos_inc;
        step <= step + 1'b1;
      end else if (alloc_go) begin
        pos  <= pos_inc;
        step <= step + 1'b1;
      end
      if (ctl.count_en && s_valid) begin
        if (match) begin
          nheld <= nheld + 1'b1;
        end
        if (!used[s_pos]) begin
          nfree <= nfree + 1'b1;
        end
      end
      if (ctl.list_en && match) begin
        result_valid  <= 1'b1;
        result.port   <= base + PORT_W'(s_pos);
        result.status <= ST_OK;
        result.last   <= (8'(got) + 8'd1 == 8'(nheld));
        got           <= got + 1'b1;
      end
      if (take) begin
        result_valid  <= 1'b1;
        result.port   <= base + PORT_W'(pos);
        result.status <= ST_OK;
        result.last   <= (8'(got) + 8'd1 == 8'(want));
        got           <= got + 1'b1;
      end
      if (ctl.emit) begin
        result_valid  <= 1'b1;
        result.port   <= '0;
        result.status <= ctl.status;
        result.last   <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fail_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |-> result.last && result.port == '0)
    else $error("failure result not single with port zero");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> cursor == '0 && used == '0)
    else $error("config write did not clear the pool");

  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.alloc_en |-> 8'(got) <= 8'(want))
    else $error("allocated more entries than wanted");

  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.list_en && match |-> 8'(got) < 8'(nheld))
    else $error("listed more entries than held");
`endif

endmodule

// File: design/npa_ctrl.sv
`timescale 1ns / 1ps

module npa_ctrl
  import npa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  npa_sts_t sts,
  output npa_ctl_t ctl
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_COUNT   = 6'b000010,
    S_DECIDE  = 6'b000100,
    S_LIST    = 6'b001000,
    S_RELEASE = 6'b010000,
    S_ALLOC   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        ctl.count_en = 1'b1;
        if (sts.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        case (sts.cmd)
          CMD_REQ_ONE: begin
            if (sts.free_zero) begin
              ctl.emit   = 1'b1;
              ctl.status = ST_NOFREE;
            end else begin
              ctl.rewind_start = 1'b1;
              state_next       = S_ALLOC;
            end
          end
          CMD_REQ_MULTI: begin
            if (sts.count_zero) begin
              ctl.emit   = 1'b1;
              ctl.status = ST_BADCOUNT;
            end else if (!sts.held_zero) begin
              if (!sts.held_eq_count) begin
                ctl.emit   = 1'b1;
                ctl.status = ST_CONFLICT;
              end else begin
                ctl.rewind_zero = 1'b1;
                state_next      = S_LIST;
              end
            end else if (sts.free_short) begin
              ctl.emit   = 1'b1;
              ctl.status = ST_NOFREE;
            end else begin
              ctl.rewind_start = 1'b1;
              state_next       = S_ALLOC;
            end
          end
          CMD_RELEASE: begin
            if (sts.held_zero) begin
              ctl.emit   = 1'b1;
              ctl.status = ST_NONE;
            end else begin
              ctl.rewind_zero = 1'b1;
              state_next      = S_RELEASE;
            end
          end
          default: begin
            if (sts.held_zero) begin
              ctl.emit   = 1'b1;
              ctl.status = ST_NONE;
            end else begin
              ctl.rewind_zero = 1'b1;
              state_next      = S_LIST;
            end
          end
        endcase
      end
      S_LIST: begin
        ctl.list_en = 1'b1;
        if (sts.scan_done) begin
          state_next = S_IDLE;
        end
      end
      S_RELEASE: begin
        ctl.release_en = 1'b1;
        if (sts.scan_done) begin
          ctl.emit   = 1'b1;
          ctl.status = ST_OK;
          state_next = S_IDLE;
        end
      end
      S_ALLOC: begin
        ctl.alloc_en = 1'b1;
        if (sts.alloc_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> state == S_COUNT)
    else $error("load did not start the count pass");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.count_en, ctl.list_en, ctl.release_en, ctl.alloc_en}))
    else $error("more than one pass active");

  a_emit_ends: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> state == S_IDLE)
    else $error("status result did not end the transaction");
`endif

endmodule

// File: design/next_fit_port_pool_allocator.sv
`timescale 1ns / 1ps
// A count pass and then one list, release or allocate pass walk the active pool entries
// one per cycle; the count, list and release passes read the owner tags through the
// owner tag memory read port.
// Throughput: one item at a time; busy is low again by the cycle after the last result.
// Results appear for one cycle each on result_valid; the receiver cannot stall.
// Reset: synchronous rst frees the pool, zeroes the cursor and both config registers.

module next_fit_port_pool_allocator
  import npa_pkg::*;
#(
  parameter int POOL_DEPTH = 64,
  parameter int OWNER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  npa_in_t               item,
  output logic                  result_valid,
  output npa_out_t              result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  npa_ctl_t ctl;
  npa_sts_t sts;

  npa_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .ctl  (ctl)
  );

  npa_dp #(
    .POOL_DEPTH(POOL_DEPTH),
    .OWNER_BITS(OWNER_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ctl         (ctl),
    .sts         (sts),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import npa_pkg::*;

  localparam int DEPTH = 64;
  localparam int RANDOM_ITEMS = 285;
  localparam int PHASE_ITEMS = 40;
  localparam int CALM_TAIL = 40;
  localparam int SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  class port_pool_scoreboard;
    bit used [DEPTH];
    logic [OWNER_W-1:0] holder [DEPTH];
    int unsigned cursor;
    logic [PORT_W-1:0] base_port;
    logic [COUNT_W-1:0] pool_size;
    npa_out_t grants_due [$];
    int errors;
    int checked;
    int status_seen [5];

    function void clear_pool();
      foreach (used[i]) begin
        used[i] = 1'b0;
        holder[i] = '0;
      end
      cursor = 0;
    endfunction

    function void reset_state();
      base_port = '0;
      pool_size = '0;
      clear_pool();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_BASE_PORT) begin
        base_port = data;
        clear_pool();
      end else if (idx == CFG_POOL_SIZE) begin
        pool_size = data[COUNT_W-1:0];
        clear_pool();
      end
    endfunction

    function int unsigned live_size();
      int unsigned n;
      int unsigned room;
      n = pool_size;
      room = 65536 - int'(base_port);
      if (n > DEPTH) n = DEPTH;
      if (n > room) n = room;
      return n;
    endfunction

    function void expect_grant(logic [PORT_W-1:0] p, status_t s, logic l);
      npa_out_t r;
      r.port = p;
      r.status = s;
      r.last = l;
      grants_due = {grants_due, r};
    endfunction

    function void list_ports(int unsigned idx [$]);
      foreach (idx[j])
        expect_grant(base_port + PORT_W'(idx[j]), ST_OK, j == idx.size() - 1);
    endfunction

    function void note_item(npa_in_t it);
      int unsigned n;
      int unsigned first;
      int unsigned want;
      int unsigned e;
      int unsigned held [$];
      int unsigned took [$];
      n = live_size();
      first = (cursor < n) ? cursor : 0;
      for (int unsigned i = 0; i < n; i++)
        if (used[i] && holder[i] == it.owner) held = {held, i};
      case (cmd_t'(it.cmd))
        CMD_REQ_ONE, CMD_REQ_MULTI: begin
          if (it.cmd == CMD_REQ_MULTI && it.count == 0) begin
            expect_grant('0, ST_BADCOUNT, 1'b1);
          end else if (it.cmd == CMD_REQ_MULTI && held.size() != 0) begin
            if (held.size() != it.count) expect_grant('0, ST_CONFLICT, 1'b1);
            else list_ports(held);
          end else begin
            want = (it.cmd == CMD_REQ_ONE) ? 1 : it.count;
            for (int unsigned k = 0; k < n && took.size() < want; k++) begin
              e = (first + k) % n;
              if (!used[e]) took = {took, e};
            end
            if (took.size() < want) begin
              expect_grant('0, ST_NOFREE, 1'b1);
            end else begin
              foreach (took[j]) begin
                used[took[j]] = 1'b1;
                holder[took[j]] = it.owner;
              end
              cursor = (took[took.size() - 1] + 1) % n;
              list_ports(took);
            end
          end
        end
        CMD_RELEASE: begin
          foreach (held[j]) begin
            used[held[j]] = 1'b0;
            holder[held[j]] = '0;
          end
          if (held.size() != 0) expect_grant('0, ST_OK, 1'b1);
          else expect_grant('0, ST_NONE, 1'b1);
        end
        CMD_QUERY: begin
          if (held.size() == 0) expect_grant('0, ST_NONE, 1'b1);
          else list_ports(held);
        end
      endcase
    endfunction

    function void check_result(npa_out_t got);
      npa_out_t want;
      if (grants_due.size() == 0) begin
        $display("%t unexpected result: port %0d status %0d last %b",
                 $time, got.port, got.status, got.last);
        errors++;
        return;
      end
      want = grants_due.pop_front();
      checked++;
      status_seen[want.status]++;
      if (got.port !== want.port || got.status !== want.status || got.last !== want.last) begin
        $display("%t mismatch: expected port %0d status %0d last %b, %s",
                 $time, want.port, want.status, want.last, "got");
        $display("%t   got port %0d status %0d last %b",
                 $time, got.port, got.status, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  npa_in_t item = '0;
  logic result_valid;
  npa_out_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  port_pool_scoreboard pool_model = new;
  int unsigned cycle_count = 0;
  int accepted = 0;
  int cfg_writes = 0;
  bit calm = 1'b0;
  logic [OWNER_W-1:0] tags [4];

  next_fit_port_pool_allocator dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_valid(result_valid),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL next_fit_port_pool_allocator");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid) pool_model.check_result(result);
  end

  task automatic pause_sender(int unsigned n_idle);
    start <= 1'b0;
    repeat (n_idle) @(posedge clk);
  endtask

  task automatic send(cmd_t c, logic [OWNER_W-1:0] who, logic [COUNT_W-1:0] cnt);
    npa_in_t it;
    it.cmd = c;
    it.owner = who;
    it.count = cnt;
    item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pool_model.note_item(it);
    accepted++;
    if (!calm && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 9));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pool_model.grants_due.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    pool_model.write_reg(idx, data);
    cfg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_pool(logic [PORT_W-1:0] b, logic [CFG_DATA_W-1:0] s);
    drain();
    write_reg(CFG_BASE_PORT, b);
    write_reg(CFG_POOL_SIZE, s);
  endtask

  task automatic random_pool();
    logic [PORT_W-1:0] b;
    logic [CFG_DATA_W-1:0] s;
    case ($urandom_range(0, 5))
      0: b = PORT_MAX - PORT_W'($urandom_range(0, 8));
      1: b = '0;
      default: b = PORT_W'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: s = '0;
      1: s = CFG_DATA_W'(DEPTH);
      2: s = CFG_DATA_W'($urandom_range(65, 127));
      default: s = CFG_DATA_W'($urandom_range(1, 12));
    endcase
    if ($urandom_range(0, 2) == 0) s[CFG_DATA_W-1:COUNT_W] = (CFG_DATA_W - COUNT_W)'($urandom);
    apply_pool(b, s);
    foreach (tags[i]) begin
      case ($urandom_range(0, 5))
        0: tags[i] = '0;
        1: tags[i] = '1;
        default: tags[i] = OWNER_W'($urandom);
      endcase
    end
  endtask

  task automatic owner_sequence();
    logic [OWNER_W-1:0] who;
    logic [COUNT_W-1:0] k;
    int unsigned n;
    n = pool_model.live_size();
    who = tags[$urandom_range(0, 3)];
    k = COUNT_W'($urandom_range(1, n / 2 + 1));
    send(CMD_REQ_MULTI, who, k);
    if ($urandom_range(0, 1)) send(CMD_QUERY, who, COUNT_W'($urandom));
    if ($urandom_range(0, 2) == 0) send(CMD_REQ_ONE, who, COUNT_W'($urandom));
    if ($urandom_range(0, 1)) send(CMD_REQ_MULTI, who, k);
    if ($urandom_range(0, 1)) send(CMD_RELEASE, who, COUNT_W'($urandom));
  endtask

  task automatic noise_item();
    logic [OWNER_W-1:0] who;
    who = $urandom_range(0, 1) ? tags[$urandom_range(0, 3)] : OWNER_W'($urandom);
    send(cmd_t'($urandom_range(0, 3)), who, COUNT_W'($urandom_range(0, 127)));
  endtask

  initial begin
    int target;
    int phase_end;
    pool_model.reset_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    calm = 1'b1;
    send(CMD_REQ_ONE, 16'h0001, 7'd0);
    send(CMD_REQ_MULTI, 16'h0001, 7'd1);
    send(CMD_RELEASE, 16'h0001, 7'd0);
    send(CMD_QUERY, 16'h0001, 7'd0);
    send(CMD_REQ_MULTI, 16'h0001, 7'd0);

    apply_pool(16'd1000, 16'd8);
    send(CMD_REQ_ONE, 16'h0001, 7'd0);
    send(CMD_REQ_ONE, 16'h0001, 7'd0);
    send(CMD_REQ_MULTI, 16'h0001, 7'd3);
    send(CMD_REQ_MULTI, 16'h0001, 7'd2);
    send(CMD_REQ_MULTI, 16'h8000, 7'd7);
    send(CMD_REQ_MULTI, 16'h8000, 7'd6);
    send(CMD_REQ_ONE, 16'h7FFF, 7'd0);
    send(CMD_RELEASE, 16'h0001, 7'd0);
    send(CMD_RELEASE, 16'h0001, 7'd0);
    send(CMD_REQ_MULTI, 16'h7FFF, 7'd2);
    send(CMD_QUERY, 16'h7FFF, 7'd0);
    drain();
    write_reg(CFG_SPARE_A, 16'hFFFF);
    send(CMD_QUERY, 16'h8000, 7'h7F);

    apply_pool(PORT_MAX, 16'd64);
    send(CMD_REQ_ONE, 16'hFFFF, 7'd0);
    send(CMD_REQ_ONE, 16'h0000, 7'd0);
    send(CMD_QUERY, 16'hFFFF, 7'd0);

    apply_pool(16'd0, 16'd127);
    send(CMD_REQ_MULTI, 16'h0000, 7'd64);
    send(CMD_REQ_MULTI, 16'hFFFF, 7'd1);
    send(CMD_RELEASE, 16'h0000, 7'd0);
    send(CMD_REQ_MULTI, 16'h5A5A, 7'd127);

    target = accepted + RANDOM_ITEMS;
    while (accepted < target) begin
      random_pool();
      calm = ($urandom_range(0, 3) == 0);
      phase_end = accepted + PHASE_ITEMS;
      while (accepted < phase_end && accepted < target) begin
        if (accepted >= target - CALM_TAIL) calm = 1'b1;
        if ($urandom_range(0, 9) < 7) owner_sequence();
        else noise_item();
        if (!calm && $urandom_range(0, 29) == 0) drain();
      end
      if (accepted < target - CALM_TAIL && $urandom_range(0, 3) == 0) begin
        drain();
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d transactions across %0d register writes; %0d results checked.",
             accepted, cfg_writes, pool_model.checked);
    $display("Outcomes: %0d granted/listed, %0d exhausted, %0d conflicts,",
             pool_model.status_seen[ST_OK], pool_model.status_seen[ST_NOFREE],
             pool_model.status_seen[ST_CONFLICT]);
    $display("  %0d bad counts, %0d none held.",
             pool_model.status_seen[ST_BADCOUNT], pool_model.status_seen[ST_NONE]);
    if (pool_model.errors == 0 && pool_model.grants_due.size() == 0) begin
      $display("PASS next_fit_port_pool_allocator");
    end else begin
      $display("FAIL next_fit_port_pool_allocator");
    end
    $finish;
  end

endmodule
